@@ hdl/lcp_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcp_pkg: shared types and constants of the command line parser
// Command codes, keyword constants, control structs and small char helpers.
// ----------------------------------------------------------------------------
package lcp_pkg;

  localparam int          LINE_CHARS_DEF = 19;
  localparam int unsigned PERIOD_MAX_DEF = 32'd65535;

  localparam int PERIOD_W = 16;
  localparam int OUT_W    = 24;

  // result codes
  typedef enum logic [3:0] {
    KIND_OFF     = 4'd0,
    KIND_SCALE_F = 4'd1,
    KIND_SCALE_C = 4'd2,
    KIND_STOP    = 4'd3,
    KIND_START   = 4'd4,
    KIND_LOG     = 4'd5,
    KIND_PERIOD  = 4'd6,
    KIND_INVALID = 4'd7,
    KIND_NEG_PER = 4'd8
  } cmd_kind_t;

  // keywords, left aligned in a 7-char field
  localparam logic [55:0] WORD_OFF     = {"OFF", 32'h0};
  localparam logic [55:0] WORD_SCALE_F = "SCALE=F";
  localparam logic [55:0] WORD_SCALE_C = "SCALE=C";
  localparam logic [55:0] WORD_STOP    = {"STOP", 24'h0};
  localparam logic [55:0] WORD_START   = {"START", 16'h0};
  localparam logic [55:0] WORD_LOG     = {"LOG", 32'h0};
  localparam logic [55:0] WORD_PERIOD  = "PERIOD=";

  localparam logic [2:0] LEN_OFF    = 3'd3;
  localparam logic [2:0] LEN_SCALE  = 3'd7;
  localparam logic [2:0] LEN_STOP   = 3'd4;
  localparam logic [2:0] LEN_START  = 3'd5;
  localparam logic [2:0] LEN_LOG    = 3'd3;
  localparam logic [2:0] LEN_PERIOD = 3'd7;

  // bit positions in the keyword match vector
  localparam int M_OFF     = 0;
  localparam int M_SCALE_F = 1;
  localparam int M_SCALE_C = 2;
  localparam int M_STOP    = 3;
  localparam int M_START   = 4;
  localparam int M_LOG     = 5;
  localparam int M_PERIOD  = 6;
  localparam int M_COUNT   = 7;

  localparam logic [7:0] CHAR_NL    = 8'h0A;
  localparam logic [7:0] CHAR_NUL   = 8'h00;
  localparam logic [7:0] CHAR_PLUS  = 8'h2B;
  localparam logic [7:0] CHAR_MINUS = 8'h2D;

  // digit accumulator controls
  typedef struct packed {
    logic clear;
    logic step;
  } lcp_acc_ctl_t;

  // true when char c at position pos does not break the keyword
  function automatic logic char_fits(logic [55:0] word, logic [2:0] wlen,
                                     logic [5:0] pos, logic [7:0] c);
    logic r;
    r = 1'b1;
    for (int k = 0; k < 7; k++) begin
      if (pos == 6'(k)) begin
        r = (3'(k) >= wlen) || (word[55-8*k -: 8] == c);
      end
    end
    return r;
  endfunction

  function automatic logic is_blank(logic [7:0] c);
    return (c == 8'h20) || ((c >= 8'h09) && (c <= 8'h0D));
  endfunction

  function automatic logic is_digit(logic [7:0] c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

endpackage

@@ hdl/sensor_command_line_parser.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sensor_command_line_parser: text command line parser
// Gathers bytes into a line buffer; at newline walks the line once and
// classifies it, updating scale, stop, shutdown and period settings.
// ----------------------------------------------------------------------------
// Walk: at newline each stored char up to the first zero byte (at most
//   LINE_CHARS) passes through the registered RAM read and then the
//   match/digit step; a zero byte ends the walk. The result then waits
//   while the previous result is still held.
// Throughput: one char per cycle between newlines; not ready from a newline
//   until its result is presented.
// Reset (rst, sync, active high): empty line, Fahrenheit, sampling running,
//   no shutdown, period 1. Line buffer contents are not cleared.
// ----------------------------------------------------------------------------
module sensor_command_line_parser #(
  parameter int          LINE_CHARS = lcp_pkg::LINE_CHARS_DEF,
  parameter int unsigned PERIOD_MAX = lcp_pkg::PERIOD_MAX_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  // input item stream
  input  logic                       s_tvalid,
  output logic                       s_tready,
  input  logic [7:0]                 s_tdata,   // [7:0] data_byte
  // result item stream
  output logic                       m_tvalid,
  input  logic                       m_tready,
  // [3:0] command_kind, [4] fahrenheit_mode, [5] sampling_stopped,
  // [6] shutdown_requested, [22:7] period_seconds, [23] zero
  output logic [lcp_pkg::OUT_W-1:0]  m_tdata
);

  localparam int ADDR_W = $clog2(LINE_CHARS);
  localparam int LEN_W  = $clog2(LINE_CHARS + 1);
  localparam int MAG_W  = $clog2(64'(PERIOD_MAX) + 64'd1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,    // address of the next char goes to the RAM
    ST_EVAL,    // char is back: match keywords, feed digit unit
    ST_FINISH   // classify, update settings, present the result
  } state_t;

  // where the number after PERIOD= stands
  typedef enum logic [1:0] {
    PH_BLANK,
    PH_DIGIT,
    PH_DONE
  } phase_t;

  state_t  state;
  phase_t  phase;

  logic [LEN_W-1:0]            line_length;
  logic                        line_overflow;
  logic [LEN_W-1:0]            idx;          // walk position, ends as text length
  logic [lcp_pkg::M_COUNT-1:0] match_ok;     // keyword prefixes still alive
  logic                        neg;
  logic                        scale_is_fahrenheit;
  logic                        stopped_flag;
  logic                        off_flag;
  logic [lcp_pkg::PERIOD_W-1:0] period_value;

  logic                        in_acc;
  logic                        nl_acc;
  logic                        out_free;
  logic [7:0]                  rd_data;
  logic [MAG_W-1:0]            mag;
  lcp_pkg::lcp_acc_ctl_t       acc_ctl;
  logic [lcp_pkg::M_COUNT-1:0] match_next;
  logic [5:0]                  pos;
  logic                        past_prefix;
  lcp_pkg::cmd_kind_t          kind;

  assign s_tready = (state == ST_IDLE);
  assign in_acc   = s_tvalid && s_tready;
  assign nl_acc   = in_acc && (s_tdata == lcp_pkg::CHAR_NL);
  assign out_free = !m_tvalid || m_tready;

  // line buffer: written while collecting, read while walking
  lcp_line_ram #(
    .DEPTH  (LINE_CHARS),
    .ADDR_W (ADDR_W)
  ) u_ram (
    .clk     (clk),
    .wr_en   (in_acc && !nl_acc && (line_length < LEN_W'(LINE_CHARS))),
    .wr_addr (line_length[ADDR_W-1:0]),
    .wr_data (s_tdata),
    .rd_addr (idx[ADDR_W-1:0]),
    .rd_data (rd_data)
  );

  // the single arithmetic unit: decimal accumulate with saturation
  lcp_digit_acc #(
    .PERIOD_MAX (PERIOD_MAX),
    .MAG_W      (MAG_W)
  ) u_acc (
    .clk   (clk),
    .ctl   (acc_ctl),
    .digit (rd_data[3:0]),
    .mag   (mag)
  );

  assign pos         = 6'(idx);
  assign past_prefix = (idx >= LEN_W'(lcp_pkg::LEN_PERIOD));

  always_comb begin
    acc_ctl.clear = nl_acc;
    acc_ctl.step  = (state == ST_EVAL) && (rd_data != lcp_pkg::CHAR_NUL) && past_prefix &&
                    (phase != PH_DONE) && lcp_pkg::is_digit(rd_data);
  end

  // keyword match for the char at the current position
  always_comb begin
    match_next = match_ok;
    match_next[lcp_pkg::M_OFF] = match_ok[lcp_pkg::M_OFF] &&
      lcp_pkg::char_fits(lcp_pkg::WORD_OFF, lcp_pkg::LEN_OFF, pos, rd_data);
    match_next[lcp_pkg::M_SCALE_F] = match_ok[lcp_pkg::M_SCALE_F] &&
      lcp_pkg::char_fits(lcp_pkg::WORD_SCALE_F, lcp_pkg::LEN_SCALE, pos, rd_data);
    match_next[lcp_pkg::M_SCALE_C] = match_ok[lcp_pkg::M_SCALE_C] &&
      lcp_pkg::char_fits(lcp_pkg::WORD_SCALE_C, lcp_pkg::LEN_SCALE, pos, rd_data);
    match_next[lcp_pkg::M_STOP] = match_ok[lcp_pkg::M_STOP] &&
      lcp_pkg::char_fits(lcp_pkg::WORD_STOP, lcp_pkg::LEN_STOP, pos, rd_data);
    match_next[lcp_pkg::M_START] = match_ok[lcp_pkg::M_START] &&
      lcp_pkg::char_fits(lcp_pkg::WORD_START, lcp_pkg::LEN_START, pos, rd_data);
    match_next[lcp_pkg::M_LOG] = match_ok[lcp_pkg::M_LOG] &&
      lcp_pkg::char_fits(lcp_pkg::WORD_LOG, lcp_pkg::LEN_LOG, pos, rd_data);
    match_next[lcp_pkg::M_PERIOD] = match_ok[lcp_pkg::M_PERIOD] &&
      lcp_pkg::char_fits(lcp_pkg::WORD_PERIOD, lcp_pkg::LEN_PERIOD, pos, rd_data);
  end

  // classification at end of walk; idx is the text length here.
  // Exact words need the length to match, prefixes need at least the word.
  always_comb begin
    if (line_overflow) begin
      kind = lcp_pkg::KIND_INVALID;
    end else if (match_ok[lcp_pkg::M_OFF] && (idx == LEN_W'(lcp_pkg::LEN_OFF))) begin
      kind = lcp_pkg::KIND_OFF;
    end else if (match_ok[lcp_pkg::M_SCALE_F] && (idx == LEN_W'(lcp_pkg::LEN_SCALE))) begin
      kind = lcp_pkg::KIND_SCALE_F;
    end else if (match_ok[lcp_pkg::M_SCALE_C] && (idx == LEN_W'(lcp_pkg::LEN_SCALE))) begin
      kind = lcp_pkg::KIND_SCALE_C;
    end else if (match_ok[lcp_pkg::M_STOP] && (idx >= LEN_W'(lcp_pkg::LEN_STOP))) begin
      kind = lcp_pkg::KIND_STOP;
    end else if (match_ok[lcp_pkg::M_START] && (idx == LEN_W'(lcp_pkg::LEN_START))) begin
      kind = lcp_pkg::KIND_START;
    end else if (match_ok[lcp_pkg::M_LOG] && (idx >= LEN_W'(lcp_pkg::LEN_LOG))) begin
      kind = lcp_pkg::KIND_LOG;
    end else if (match_ok[lcp_pkg::M_PERIOD] && past_prefix) begin
      kind = (neg && (mag != '0)) ? lcp_pkg::KIND_NEG_PER : lcp_pkg::KIND_PERIOD;
    end else begin
      kind = lcp_pkg::KIND_INVALID;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state               <= ST_IDLE;
      phase               <= PH_BLANK;
      line_length         <= '0;
      line_overflow       <= 1'b0;
      idx                 <= '0;
      match_ok            <= '1;
      neg                 <= 1'b0;
      scale_is_fahrenheit <= 1'b1;
      stopped_flag        <= 1'b0;
      off_flag            <= 1'b0;
      period_value        <= lcp_pkg::PERIOD_W'(1);
      m_tvalid            <= 1'b0;
    end else begin
      // a new result replaces a taken one in the same cycle
      if ((state == ST_FINISH) && out_free) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (nl_acc) begin
            idx      <= '0;
            match_ok <= '1;
            neg      <= 1'b0;
            phase    <= PH_BLANK;
            state    <= ST_READ;
          end else if (in_acc) begin
            // chars past the buffer are dropped and mark the line overlong
            if (line_length < LEN_W'(LINE_CHARS)) begin
              line_length <= line_length + LEN_W'(1);
            end else begin
              line_overflow <= 1'b1;
            end
          end
        end
        ST_READ: begin
          state <= (idx == line_length) ? ST_FINISH : ST_EVAL;
        end
        ST_EVAL: begin
          if (rd_data == lcp_pkg::CHAR_NUL) begin
            // line ends at its first zero byte
            state <= ST_FINISH;
          end else begin
            match_ok <= match_next;
            if (past_prefix) begin
              case (phase)
                PH_BLANK: begin
                  if (lcp_pkg::is_blank(rd_data)) begin
                    phase <= PH_BLANK;
                  end else if ((rd_data == lcp_pkg::CHAR_PLUS) ||
                               (rd_data == lcp_pkg::CHAR_MINUS)) begin
                    neg   <= (rd_data == lcp_pkg::CHAR_MINUS);
                    phase <= PH_DIGIT;
                  end else if (lcp_pkg::is_digit(rd_data)) begin
                    phase <= PH_DIGIT;
                  end else begin
                    phase <= PH_DONE;
                  end
                end
                PH_DIGIT: begin
                  if (!lcp_pkg::is_digit(rd_data)) begin
                    phase <= PH_DONE;
                  end
                end
                default: begin
                  phase <= PH_DONE;
                end
              endcase
            end
            idx   <= idx + LEN_W'(1);
            state <= ST_READ;
          end
        end
        ST_FINISH: begin
          if (out_free) begin
            unique case (kind)
              lcp_pkg::KIND_OFF:     off_flag            <= 1'b1;
              lcp_pkg::KIND_SCALE_F: scale_is_fahrenheit <= 1'b1;
              lcp_pkg::KIND_SCALE_C: scale_is_fahrenheit <= 1'b0;
              lcp_pkg::KIND_STOP:    stopped_flag        <= 1'b1;
              lcp_pkg::KIND_START:   stopped_flag        <= 1'b0;
              lcp_pkg::KIND_PERIOD:  period_value        <= lcp_pkg::PERIOD_W'(mag);
              default: ;
            endcase
            m_tdata[3:0] <= kind;
            m_tdata[4]   <= (kind == lcp_pkg::KIND_SCALE_F) ? 1'b1 :
                            (kind == lcp_pkg::KIND_SCALE_C) ? 1'b0 : scale_is_fahrenheit;
            m_tdata[5]   <= (kind == lcp_pkg::KIND_STOP)  ? 1'b1 :
                            (kind == lcp_pkg::KIND_START) ? 1'b0 : stopped_flag;
            m_tdata[6]   <= (kind == lcp_pkg::KIND_OFF) ? 1'b1 : off_flag;
            m_tdata[22:7] <= (kind == lcp_pkg::KIND_PERIOD) ? lcp_pkg::PERIOD_W'(mag)
                                                            : period_value;
            m_tdata[23]  <= 1'b0;
            line_length   <= '0;
            line_overflow <= 1'b0;
            state         <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // overlong mark only once the buffer is full
  a_overflow_full: assert property (@(posedge clk) disable iff (rst)
    line_overflow |-> (line_length == LEN_W'(LINE_CHARS)))
    else $error("overflow set with buffer not full");

  // a newline always starts the walk
  a_nl_walks: assert property (@(posedge clk) disable iff (rst)
    nl_acc |=> (state == ST_READ))
    else $error("newline did not start line walk");

  // results only come out of the finish step
  a_result_src: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(state == ST_FINISH))
    else $error("result raised outside finish step");

  // walk never runs past the stored line
  a_walk_bound: assert property (@(posedge clk) disable iff (rst)
    (state == ST_EVAL) |-> (idx < line_length))
    else $error("walk index beyond line length");

endmodule

@@ hdl/lcp_line_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcp_line_ram: line buffer
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module lcp_line_ram #(
  parameter int DEPTH  = lcp_pkg::LINE_CHARS_DEF,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [7:0]        wr_data,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [7:0]        rd_data
);

  logic [7:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

@@ hdl/lcp_digit_acc.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcp_digit_acc: decimal accumulator
// mag <= min(mag * 10 + digit, PERIOD_MAX), one digit per step.
// ----------------------------------------------------------------------------
module lcp_digit_acc #(
  parameter int unsigned PERIOD_MAX = lcp_pkg::PERIOD_MAX_DEF,
  parameter int          MAG_W      = $clog2(64'(PERIOD_MAX) + 64'd1)
) (
  input  logic                 clk,
  input  lcp_pkg::lcp_acc_ctl_t ctl,
  input  logic [3:0]           digit,
  output logic [MAG_W-1:0]     mag
);

  localparam int PROD_W = MAG_W + 4;

  logic [PROD_W-1:0] prod;

  // x10 as two shifts and an add
  assign prod = ({1'b0, mag, 3'b000} + {3'b000, mag, 1'b0}) + PROD_W'(digit);

  always_ff @(posedge clk) begin
    if (ctl.clear) begin
      mag <= '0;
    end else if (ctl.step) begin
      if (prod > PROD_W'(PERIOD_MAX)) begin
        mag <= MAG_W'(PERIOD_MAX);
      end else begin
        mag <= prod[MAG_W-1:0];
      end
    end
  end

endmodule

@@ test/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for sensor_command_line_parser
// Streams command text into the parser byte by byte and checks every line
// result field by field against an in-bench model of the line classifier.
// Stimulus is a short directed opener followed by random command lines. Most
// lines are well formed, and the rest are mutated, overlong, zero-cut, empty or noise lines.
// Three phases vary idling on the input and result sides.
// ----------------------------------------------------------------------------
module testbench;

  localparam int NUM_CHARS  = lcp_pkg::LINE_CHARS_DEF;
  localparam int MAX_PERIOD = lcp_pkg::PERIOD_MAX_DEF;

  typedef struct {
    lcp_pkg::cmd_kind_t kind;
    logic        fahr;
    logic        stopped;
    logic        off;
    logic [15:0] period;
  } line_result_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              s_tvalid = 1'b0;
  logic              s_tready;
  logic [7:0]        s_tdata = 8'h00;
  logic              m_tvalid;
  logic              m_tready = 1'b0;
  logic [lcp_pkg::OUT_W-1:0] m_tdata;

  // bytes waiting to go out, and line results still owed by the parser
  logic [7:0]   tx_bytes[$];
  line_result_t expected_lines[$];

  int send_idle_pct = 12;
  int recv_idle_pct = 50;
  int error_count = 0;

  // model state: line buffer and the current settings
  logic [7:0]  line_buf[NUM_CHARS];
  int          line_len = 0;
  logic        line_ovf = 1'b0;
  logic        fahr_now = 1'b1;
  logic        stopped_now = 1'b0;
  logic        off_now = 1'b0;
  logic [15:0] period_now = 16'd1;

  sensor_command_line_parser i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always #6 clk = ~clk;

  // ---------------------------------------------------------------- model --

  // keyword compare against the line cut at its first zero byte
  function automatic logic word_match(input string w, input int tlen,
                                      input logic exact);
    logic ok;
    ok = 1'b1;
    for (int k = 0; k < w.len(); k++) begin
      if (k >= tlen || line_buf[k] != 8'(w[k])) ok = 1'b0;
    end
    return ok && (!exact || tlen == w.len());
  endfunction

  // classify the finished line and apply its effect on the settings
  function automatic lcp_pkg::cmd_kind_t classify_line(input int tlen);
    int          idx;
    logic        neg;
    int unsigned mag;
    logic [7:0]  c;
    if (line_ovf) return lcp_pkg::KIND_INVALID;
    if (word_match("OFF", tlen, 1'b1)) begin
      off_now = 1'b1;
      return lcp_pkg::KIND_OFF;
    end
    if (word_match("SCALE=F", tlen, 1'b1)) begin
      fahr_now = 1'b1;
      return lcp_pkg::KIND_SCALE_F;
    end
    if (word_match("SCALE=C", tlen, 1'b1)) begin
      fahr_now = 1'b0;
      return lcp_pkg::KIND_SCALE_C;
    end
    if (word_match("STOP", tlen, 1'b0)) begin
      stopped_now = 1'b1;
      return lcp_pkg::KIND_STOP;
    end
    if (word_match("START", tlen, 1'b1)) begin
      stopped_now = 1'b0;
      return lcp_pkg::KIND_START;
    end
    if (word_match("LOG", tlen, 1'b0)) return lcp_pkg::KIND_LOG;
    if (!word_match("PERIOD=", tlen, 1'b0)) return lcp_pkg::KIND_INVALID;

    // atoi-style number: blanks, optional sign, digits, saturating
    idx = 7;
    neg = 1'b0;
    mag = 0;
    while (idx < tlen && (line_buf[idx] == 8'h20 ||
           (line_buf[idx] >= 8'h09 && line_buf[idx] <= 8'h0D))) idx++;
    if (idx < tlen && (line_buf[idx] == lcp_pkg::CHAR_PLUS ||
                       line_buf[idx] == lcp_pkg::CHAR_MINUS)) begin
      neg = (line_buf[idx] == lcp_pkg::CHAR_MINUS);
      idx++;
    end
    while (idx < tlen && line_buf[idx] >= 8'h30 && line_buf[idx] <= 8'h39) begin
      c = line_buf[idx] - 8'h30;
      mag = mag * 10 + c;
      if (mag > MAX_PERIOD) mag = MAX_PERIOD;
      idx++;
    end
    if (neg && mag != 0) return lcp_pkg::KIND_NEG_PER;
    period_now = 16'(mag);
    return lcp_pkg::KIND_PERIOD;
  endfunction

  // take one accepted byte; a newline queues the expected line result
  task automatic predict_byte(input logic [7:0] b);
    int           tlen;
    line_result_t r;
    if (b != lcp_pkg::CHAR_NL) begin
      if (line_len < NUM_CHARS) begin
        line_buf[line_len] = b;
        line_len++;
      end else begin
        line_ovf = 1'b1;
      end
    end else begin
      tlen = line_len;
      for (int k = line_len - 1; k >= 0; k--) begin
        if (line_buf[k] == lcp_pkg::CHAR_NUL) tlen = k;
      end
      r.kind    = classify_line(tlen);
      line_len  = 0;
      line_ovf  = 1'b0;
      r.fahr    = fahr_now;
      r.stopped = stopped_now;
      r.off     = off_now;
      r.period  = period_now;
      expected_lines.push_back(r);
    end
  endtask

  // ------------------------------------------------------------- checking --

  task automatic flag_error(input string msg);
    error_count++;
    if (error_count <= 10) $display("ERROR at %0t: %s", $time, msg);
  endtask

  task automatic check_line_result(input logic [lcp_pkg::OUT_W-1:0] d);
    line_result_t want;
    if (expected_lines.size() == 0) begin
      flag_error($sformatf("unexpected result item, data %h", d));
    end else begin
      want = expected_lines.pop_front();
      if (d[3:0] != want.kind)
        flag_error($sformatf("command_kind exp %0d got %0d", want.kind, d[3:0]));
      if (d[4] != want.fahr)
        flag_error($sformatf("fahrenheit_mode exp %0b got %0b", want.fahr, d[4]));
      if (d[5] != want.stopped)
        flag_error($sformatf("sampling_stopped exp %0b got %0b", want.stopped, d[5]));
      if (d[6] != want.off)
        flag_error($sformatf("shutdown_requested exp %0b got %0b", want.off, d[6]));
      if (d[22:7] != want.period)
        flag_error($sformatf("period_seconds exp %0d got %0d", want.period, d[22:7]));
    end
  endtask

  // -------------------------------------------------------------- drivers --

  // input side: hold an offered byte until taken, then maybe idle
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!s_tvalid || s_tready) begin
      if (s_tvalid) begin
        predict_byte(s_tdata);
        void'(tx_bytes.pop_front());
      end
      if (tx_bytes.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        s_tvalid <= 1'b1;
        s_tdata  <= tx_bytes[0];
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // result side: random back-pressure, check each accepted result
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) check_line_result(m_tdata);
      m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // ------------------------------------------------------------ stimulus --

  task automatic queue_text(input string s);
    for (int k = 0; k < s.len(); k++) tx_bytes.push_back(8'(s[k]));
  endtask

  // any byte but newline, so the line does not end early
  function automatic logic [7:0] rand_char();
    logic [7:0] c;
    c = 8'($urandom_range(255));
    if (c == lcp_pkg::CHAR_NL) c = 8'h20;
    return c;
  endfunction

  function automatic string keyword_text(input int sel);
    case (sel)
      0: return "OFF";
      1: return "SCALE=F";
      2: return "SCALE=C";
      3: return "STOP";
      4: return "START";
      5: return "LOG";
      default: return "PERIOD=";
    endcase
  endfunction

  task automatic queue_random_line();
    int    pick;
    int    n;
    int    start;
    string kw;
    logic [7:0] blanks[5];
    blanks = '{8'h20, 8'h09, 8'h0B, 8'h0C, 8'h0D};
    start = tx_bytes.size();
    pick  = $urandom_range(99);
    if (pick < 30) begin
      // period setting: blanks, sign, digits (long runs saturate), junk
      queue_text("PERIOD=");
      n = ($urandom_range(3) == 0) ? $urandom_range(1, 3) : 0;
      repeat (n) tx_bytes.push_back(blanks[$urandom_range(4)]);
      case ($urandom_range(5))
        0:       tx_bytes.push_back(lcp_pkg::CHAR_PLUS);
        1, 2:    tx_bytes.push_back(lcp_pkg::CHAR_MINUS);
        default: ;
      endcase
      n = ($urandom_range(4) == 0) ? $urandom_range(6, 12) : $urandom_range(0, 5);
      repeat (n) tx_bytes.push_back(8'h30 + 8'($urandom_range(9)));
      if ($urandom_range(4) == 0) repeat ($urandom_range(1, 3)) tx_bytes.push_back(rand_char());
    end else if (pick < 55) begin
      // exact keyword, sometimes with a suffix or one char broken
      kw = keyword_text($urandom_range(5));
      queue_text(kw);
      n = $urandom_range(9);
      if (n < 3) begin
        repeat ($urandom_range(1, 3)) tx_bytes.push_back(rand_char());
      end else if (n < 5) begin
        tx_bytes[tx_bytes.size() - 1 - $urandom_range(kw.len() - 1)] = rand_char();
      end
    end else if (pick < 65) begin
      // prefix commands with an arbitrary tail
      if ($urandom_range(1)) begin
        queue_text("STOP");
      end else begin
        queue_text("LOG");
      end
      repeat ($urandom_range(12)) tx_bytes.push_back(rand_char());
    end else if (pick < 73) begin
      // overlong line, possibly starting like a valid command
      if ($urandom_range(1)) queue_text(keyword_text($urandom_range(6)));
      n = $urandom_range(20, 28);
      while (tx_bytes.size() - start < n) tx_bytes.push_back(rand_char());
    end else if (pick < 80) begin
      // zero byte cuts the line short
      queue_text(keyword_text($urandom_range(6)));
      if ($urandom_range(1)) tx_bytes.push_back(8'h30 + 8'($urandom_range(9)));
      tx_bytes.push_back(lcp_pkg::CHAR_NUL);
      repeat ($urandom_range(4)) tx_bytes.push_back(rand_char());
    end else if (pick < 85) begin
      // empty line
    end else begin
      // raw noise, length up to the buffer size and exactly at it
      n = ($urandom_range(3) == 0) ? NUM_CHARS : $urandom_range(1, NUM_CHARS);
      repeat (n) tx_bytes.push_back(8'($urandom_range(255)));
    end
    tx_bytes.push_back(lcp_pkg::CHAR_NL);
  endtask

  task automatic fill_random(input int n_bytes);
    while (tx_bytes.size() < n_bytes) queue_random_line();
  endtask

  task automatic drain_input();
    while (tx_bytes.size() != 0 || s_tvalid) @(negedge clk);
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed opener: scale change, stop and start, byte extremes, empty
    // line, then shutdown
    queue_text("SCALE=C\n");
    queue_text("STOP\n");
    tx_bytes.push_back(8'hFF);
    tx_bytes.push_back(lcp_pkg::CHAR_NUL);
    tx_bytes.push_back(lcp_pkg::CHAR_NL);
    tx_bytes.push_back(lcp_pkg::CHAR_NL);
    queue_text("START\n");
    queue_text("OFF\n");
    fill_random(550);
    drain_input();

    send_idle_pct = 50;
    recv_idle_pct = 12;
    fill_random(550);
    drain_input();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    fill_random(550);
    drain_input();

    while (expected_lines.size() != 0) @(posedge clk);
    // a trailing partial line could still be in the walk; allow the worst case
    repeat (2 * NUM_CHARS + 40) @(posedge clk);

    if (error_count == 0 && expected_lines.size() == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

  // watchdog well beyond the slowest legal run
  initial begin
    #20_000_000;
    $display("testbench: done, errors");
    $finish;
  end

endmodule
